/* rtl/core/jte_pkg.sv */
`default_nettype none
package jte_pkg;

    localparam int MAX_JOBS = 16;

    localparam int FUNC_W = 3;
    localparam int PID_W  = 22;
    localparam int JID_W  = 5;
    localparam int ST_W   = 2;
    localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    localparam logic [JID_W-1:0] MAX_JID  = JID_W'(MAX_JOBS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);

    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEL  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FPID = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FJID = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SET  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic apply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stop;
        logic out_free;
    } ctrl_sts_t;

endpackage
`default_nettype wire

/* rtl/core/jte_ctrl.sv */
`default_nettype none
module jte_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  jte_pkg::ctrl_sts_t  sts,
    output jte_pkg::ctrl_cmd_t  cmd
);
    import jte_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.stop) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        cmd.apply = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
            end
            ST_APPLY: begin
                cmd.apply = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/jte_dp.sv */
`default_nettype none
module jte_dp (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  jte_pkg::ctrl_cmd_t           cmd,
    output jte_pkg::ctrl_sts_t           sts,
    input  wire [jte_pkg::FUNC_W-1:0]    s_func,
    input  wire [jte_pkg::PID_W-1:0]     s_proc_id,
    input  wire [jte_pkg::JID_W-1:0]     s_job_number,
    input  wire [jte_pkg::ST_W-1:0]      s_new_state,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_ok,
    output logic [jte_pkg::JID_W-1:0]    m_out_job_id,
    output logic [jte_pkg::PID_W-1:0]    m_out_proc_id,
    output logic [jte_pkg::ST_W-1:0]     m_out_state
);
    import jte_pkg::*;

    // job table
    logic [PID_W-1:0] tbl_pid_reg [MAX_JOBS];
    logic [JID_W-1:0] tbl_jid_reg [MAX_JOBS];
    logic [ST_W-1:0]  tbl_st_reg  [MAX_JOBS];
    logic [JID_W-1:0] next_jid_reg;

    // captured transaction
    logic [FUNC_W-1:0] func_reg;
    logic [PID_W-1:0]  pid_reg;
    logic [JID_W-1:0]  jid_reg;
    logic [ST_W-1:0]   st_reg;

    // scan
    logic [IDX_W-1:0] idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [JID_W-1:0] cap_jid_reg;
    logic [PID_W-1:0] cap_pid_reg;
    logic [ST_W-1:0]  cap_st_reg;
    logic [JID_W-1:0] max_reg;

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [JID_W-1:0] out_jid_reg;
    logic [PID_W-1:0] out_pid_reg;
    logic [ST_W-1:0]  out_st_reg;

    logic [PID_W-1:0] ent_pid;
    logic [JID_W-1:0] ent_jid;
    logic [ST_W-1:0]  ent_st;
    logic             match_now;
    logic             first_hit;
    logic [JID_W-1:0] add_jid;
    logic [JID_W-1:0] add_next;

    assign ent_pid = tbl_pid_reg[idx_reg];
    assign ent_jid = tbl_jid_reg[idx_reg];
    assign ent_st  = tbl_st_reg[idx_reg];

    always_comb begin
        case (func_reg)
            FN_ADD:                  match_now = (pid_reg != '0) && (ent_pid == '0);
            FN_DEL, FN_FPID, FN_SET: match_now = (pid_reg != '0) && (ent_pid == pid_reg);
            FN_FJID:                 match_now = (jid_reg != '0) && (ent_jid == jid_reg);
            default:                 match_now = 1'b0;
        endcase
    end

    assign first_hit = match_now && !hit_reg;

    // delete keeps scanning to find the largest remaining job id
    assign sts.stop     = (idx_reg == LAST_IDX) || (first_hit && (func_reg != FN_DEL));
    assign sts.out_free = !out_valid_reg || m_ready;

    assign add_jid  = ((next_jid_reg == '0) || (next_jid_reg > MAX_JID))
                      ? JID_W'(1) : next_jid_reg;
    assign add_next = (add_jid == MAX_JID) ? JID_W'(1) : add_jid + JID_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            pid_reg  <= s_proc_id;
            jid_reg  <= s_job_number;
            st_reg   <= s_new_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            max_reg <= '0;
        end else if (cmd.load) begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            max_reg <= '0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (first_hit) begin
                hit_reg <= 1'b1;
            end else if (ent_jid > max_reg) begin
                max_reg <= ent_jid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && first_hit) begin
            slot_reg    <= idx_reg;
            cap_jid_reg <= ent_jid;
            cap_pid_reg <= ent_pid;
            cap_st_reg  <= ent_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_JOBS; i++) begin
                tbl_pid_reg[i] <= '0;
                tbl_jid_reg[i] <= '0;
                tbl_st_reg[i]  <= '0;
            end
            next_jid_reg <= JID_W'(1);
        end else if (cmd.apply && hit_reg) begin
            case (func_reg)
                FN_ADD: begin
                    tbl_pid_reg[slot_reg] <= pid_reg;
                    tbl_jid_reg[slot_reg] <= add_jid;
                    tbl_st_reg[slot_reg]  <= st_reg;
                    next_jid_reg          <= add_next;
                end
                FN_DEL: begin
                    tbl_pid_reg[slot_reg] <= '0;
                    tbl_jid_reg[slot_reg] <= '0;
                    tbl_st_reg[slot_reg]  <= '0;
                    next_jid_reg          <= max_reg + JID_W'(1);
                end
                FN_SET: begin
                    tbl_st_reg[slot_reg] <= st_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.apply) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            out_ok_reg  <= hit_reg;
            out_jid_reg <= '0;
            out_pid_reg <= '0;
            out_st_reg  <= '0;
            if (hit_reg) begin
                out_jid_reg <= cap_jid_reg;
                out_pid_reg <= cap_pid_reg;
                out_st_reg  <= cap_st_reg;
                case (func_reg)
                    FN_ADD: begin
                        out_jid_reg <= add_jid;
                        out_pid_reg <= pid_reg;
                        out_st_reg  <= st_reg;
                    end
                    FN_SET:  out_st_reg <= st_reg;
                    default: ;
                endcase
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_ok          = out_ok_reg;
    assign m_out_job_id  = out_jid_reg;
    assign m_out_proc_id = out_pid_reg;
    assign m_out_state   = out_st_reg;

endmodule
`default_nettype wire

/* rtl/core/job_table_engine_core.sv */
// Channel  Handshake           Payload
// s_       s_valid / s_ready   s_func, s_proc_id, s_job_number, s_new_state
// m_       m_valid / m_ready   m_ok, m_out_job_id, m_out_proc_id, m_out_state
//
// One transaction at a time: capture, then a scan of one table entry per cycle,
// then a step that updates the table and loads the result register.
// Lookups, add and set state stop at the first hit; delete always scans all
// MAX_JOBS entries to get the largest remaining job id.
// Synchronous active-low reset clears the table; next job id resets to 1.
// A stalled result holds the update step; s_ready stays low until it is taken.
`default_nettype none
module job_table_engine_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [jte_pkg::FUNC_W-1:0]    s_func,
    input  wire [jte_pkg::PID_W-1:0]     s_proc_id,
    input  wire [jte_pkg::JID_W-1:0]     s_job_number,
    input  wire [jte_pkg::ST_W-1:0]      s_new_state,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_ok,
    output logic [jte_pkg::JID_W-1:0]    m_out_job_id,
    output logic [jte_pkg::PID_W-1:0]    m_out_proc_id,
    output logic [jte_pkg::ST_W-1:0]     m_out_state
);
    import jte_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    jte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    jte_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_func        (s_func),
        .s_proc_id     (s_proc_id),
        .s_job_number  (s_job_number),
        .s_new_state   (s_new_state),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_out_job_id  (m_out_job_id),
        .m_out_proc_id (m_out_proc_id),
        .m_out_state   (m_out_state)
    );

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.step && !s_ready))
        else $error("accepted transaction did not start a scan");

    a_result_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.apply))
        else $error("result appeared without a table update step");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |->
            (m_out_job_id == '0 && m_out_proc_id == '0 && m_out_state == '0))
        else $error("failed transaction carries nonzero fields");
`endif

endmodule
`default_nettype wire
